>>> rtl/ddt_pkg.sv
// Shared types for the drawdown tracker.
package ddt_pkg;

    // Sequencer states of the tracker
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

>>> rtl/ddt_if.sv
// Valid/ready channel interfaces for the drawdown tracker input and result.
interface ddt_item_if #(
    parameter int VALUE_WIDTH = 48
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    logic                   first;

    modport source (output valid, output value, output first, input ready);
    modport sink (input valid, input value, input first, output ready);
endinterface

interface ddt_result_if #(
    parameter int INDEX_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS:0]   drawdown;
    logic [FRACTION_BITS:0]   worst_drawdown;
    logic [INDEX_WIDTH-1:0]   dd_start_index;
    logic [INDEX_WIDTH-1:0]   dd_end_index;
    logic [INDEX_WIDTH-1:0]   run_length;
    logic [INDEX_WIDTH-1:0]   longest_run;

    modport source (
        output valid, output drawdown, output worst_drawdown, output dd_start_index,
        output dd_end_index, output run_length, output longest_run, input ready
    );
    modport sink (
        input valid, input drawdown, input worst_drawdown, input dd_start_index,
        input dd_end_index, input run_length, input longest_run, output ready
    );
endinterface

>>> rtl/ddt_divider.sv
// Bit-serial restoring divider: (dividend << FRACTION_BITS) / divisor, one quotient bit a cycle.
module ddt_divider #(
    parameter int VALUE_WIDTH   = 48,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [VALUE_WIDTH-1:0]   i_dividend,
    input  logic [VALUE_WIDTH-1:0]   i_divisor,
    output logic                     o_last,
    output logic [FRACTION_BITS:0]   o_quotient
);
    localparam int QW = FRACTION_BITS + 1;
    localparam int CW = $clog2(QW);

    logic [VALUE_WIDTH:0]   r_rem;
    logic [VALUE_WIDTH:0]   n_rem;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [QW-1:0]          r_quo;
    logic [CW-1:0]          r_count;
    logic                   r_busy;
    logic                   w_take;
    logic [VALUE_WIDTH:0]   w_left;

    // Trial subtract, then shift the partial remainder up one place
    always_comb begin
        w_take = r_rem >= {1'b0, r_div};
        w_left = w_take ? (r_rem - {1'b0, r_div}) : r_rem;
        n_rem  = {w_left[VALUE_WIDTH-1:0], 1'b0};
    end

    // Load on start, then advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_rem   <= {1'b0, i_dividend};
            r_div   <= i_divisor;
            r_count <= CW'(QW - 1);
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            r_rem   <= n_rem;
            r_quo   <= {r_quo[QW-2:0], w_take};
            r_count <= r_count - 1'b1;
            r_busy  <= (r_count != '0);
        end
    end

    assign o_last     = r_busy && (r_count == '0);
    assign o_quotient = r_quo;
endmodule

>>> rtl/drawdown_tracker.sv
// Drawdown tracker: running peak, current and maximum drawdown, and under-peak runs.
// An item that needs a division passes from acceptance through ST_CALC, ST_DIV and
// ST_FINISH before the next item is accepted; the bit-serial divider produces one
// quotient bit a cycle in ST_DIV; ST_FINISH commits once the result register is free.
// Items that start a series, set a new peak or meet a zero peak skip ST_DIV.
// Synchronous active-low reset idles the block and closes the series.
module drawdown_tracker
    import ddt_pkg::*;
#(
    parameter int VALUE_WIDTH   = 48,
    parameter int INDEX_WIDTH   = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ddt_item_if.sink      i_item,
    ddt_result_if.source  o_result
);
    localparam int QW = FRACTION_BITS + 1;

    t_state r_state;
    t_state n_state;

    // Captured transaction and decisions
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_first;
    logic                   r_start;
    logic                   r_greater;
    logic                   r_div_used;

    // Tracker state
    logic                   r_open;
    logic [VALUE_WIDTH-1:0] r_peak;
    logic [INDEX_WIDTH-1:0] r_peak_pos;
    logic [INDEX_WIDTH-1:0] r_item_pos;
    logic [QW-1:0]          r_worst;
    logic [INDEX_WIDTH-1:0] r_worst_start;
    logic [INDEX_WIDTH-1:0] r_worst_end;
    logic [INDEX_WIDTH-1:0] r_run;
    logic [INDEX_WIDTH-1:0] r_best;

    // Output register
    logic                   r_out_valid;
    logic [QW-1:0]          r_o_dd;
    logic [QW-1:0]          r_o_max;
    logic [INDEX_WIDTH-1:0] r_o_start;
    logic [INDEX_WIDTH-1:0] r_o_end;
    logic [INDEX_WIDTH-1:0] r_o_run;
    logic [INDEX_WIDTH-1:0] r_o_best;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_commit;
    logic                   w_calc_start;
    logic                   w_calc_greater;
    logic                   w_need_div;
    logic                   w_div_start;
    logic                   w_div_last;
    logic [QW-1:0]          w_quotient;
    logic [QW-1:0]          w_dd;
    logic [INDEX_WIDTH-1:0] w_pos_inc;
    logic [INDEX_WIDTH-1:0] w_run_inc;

    // Combinational next values for the commit
    logic [VALUE_WIDTH-1:0] n_peak;
    logic [INDEX_WIDTH-1:0] n_peak_pos;
    logic [INDEX_WIDTH-1:0] n_item_pos;
    logic [QW-1:0]          n_worst;
    logic [INDEX_WIDTH-1:0] n_worst_start;
    logic [INDEX_WIDTH-1:0] n_worst_end;
    logic [INDEX_WIDTH-1:0] n_run;
    logic [INDEX_WIDTH-1:0] n_best;

    assign w_accept   = i_item.valid && i_item.ready;
    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_commit   = (r_state == ST_FINISH) && w_out_free;

    // Classify the captured item
    always_comb begin
        w_calc_start   = r_first || !r_open;
        w_calc_greater = r_value > r_peak;
        w_need_div     = !w_calc_start && !w_calc_greater && (r_peak != '0);
    end

    ddt_divider #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_peak - r_value),
        .i_divisor  (r_peak),
        .o_last     (w_div_last),
        .o_quotient (w_quotient)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_CALC;
            ST_CALC:   n_state = w_need_div ? ST_DIV : ST_FINISH;
            ST_DIV:    if (w_div_last) n_state = ST_FINISH;
            ST_FINISH: if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // State machine outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_div_start  = 1'b0;
        unique case (r_state)
            ST_IDLE:   i_item.ready = 1'b1;
            ST_CALC:   w_div_start  = w_need_div;
            ST_DIV:    ;
            ST_FINISH: ;
            default:   ;
        endcase
    end

    // Work out the updated tracker state for this item
    always_comb begin
        w_dd      = r_div_used ? w_quotient : '0;
        w_pos_inc = (r_item_pos == '1) ? r_item_pos : r_item_pos + 1'b1;
        w_run_inc = (r_run == '1) ? r_run : r_run + 1'b1;

        n_peak        = r_peak;
        n_peak_pos    = r_peak_pos;
        n_item_pos    = w_pos_inc;
        n_worst       = r_worst;
        n_worst_start = r_worst_start;
        n_worst_end   = r_worst_end;
        n_run         = r_run;
        n_best        = r_best;

        if (r_start) begin
            n_peak        = r_value;
            n_peak_pos    = '0;
            n_item_pos    = '0;
            n_worst       = '0;
            n_worst_start = '0;
            n_worst_end   = '0;
            n_run         = '0;
            n_best        = '0;
        end else begin
            if (r_greater) begin
                n_peak     = r_value;
                n_peak_pos = w_pos_inc;
            end else if (w_dd > r_worst) begin
                n_worst       = w_dd;
                n_worst_start = r_peak_pos;
                n_worst_end   = w_pos_inc;
            end
            // Count runs of items whose drawdown is above zero
            if (w_dd != '0) begin
                n_run = w_run_inc;
                if (w_run_inc > r_best) n_best = w_run_inc;
            end else begin
                n_run = '0;
            end
        end
    end

    // Sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_open      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_open      <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the transaction and the decisions made on it
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value <= i_item.value;
            r_first <= i_item.first;
        end
        if (r_state == ST_CALC) begin
            r_start    <= w_calc_start;
            r_greater  <= w_calc_greater;
            r_div_used <= w_need_div;
        end
    end

    // Commit tracker state and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak        <= '0;
            r_peak_pos    <= '0;
            r_item_pos    <= '0;
            r_worst       <= '0;
            r_worst_start <= '0;
            r_worst_end   <= '0;
            r_run         <= '0;
            r_best        <= '0;
        end else if (w_commit) begin
            r_peak        <= n_peak;
            r_peak_pos    <= n_peak_pos;
            r_item_pos    <= n_item_pos;
            r_worst       <= n_worst;
            r_worst_start <= n_worst_start;
            r_worst_end   <= n_worst_end;
            r_run         <= n_run;
            r_best        <= n_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_o_dd    <= w_dd;
            r_o_max   <= n_worst;
            r_o_start <= n_worst_start;
            r_o_end   <= n_worst_end;
            r_o_run   <= n_run;
            r_o_best  <= n_best;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.drawdown       = r_o_dd;
    assign o_result.worst_drawdown = r_o_max;
    assign o_result.dd_start_index = r_o_start;
    assign o_result.dd_end_index   = r_o_end;
    assign o_result.run_length     = r_o_run;
    assign o_result.longest_run    = r_o_best;
endmodule
